// ===== sv/double_ended_queue_top_defines.svh =====
// assertion macros shared by the double-ended queue checker
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define DEQ_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("deque check failed");

// next-cycle implication, disabled while reset is high
`define DEQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("deque check failed");

`endif

// ===== sv/deq_pkg.sv =====
// types and codes shared by the double-ended queue modules
package deq_pkg;

   localparam int VALUE_W = 64;

   localparam logic [1:0] REQ_PUSH_TAIL = 2'd0;
   localparam logic [1:0] REQ_PUSH_HEAD = 2'd1;
   localparam logic [1:0] REQ_POP_TAIL  = 2'd2;
   localparam logic [1:0] REQ_POP_HEAD  = 2'd3;

   localparam logic [1:0] STAT_OK          = 2'd0;
   localparam logic [1:0] STAT_EMPTY_ERROR = 2'd1;
   localparam logic [1:0] STAT_FULL_ERROR  = 2'd2;

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef enum logic {
      ST_IDLE,
      ST_RESP
   } deq_state_type;

   typedef struct packed {
      logic exec;
   } deq_cmd_type;

endpackage

// ===== sv/deq_ctrl.sv =====
// controller state machine for the double-ended queue
module deq_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output deq_pkg::deq_cmd_type cmd
);
   import deq_pkg::*;

   deq_state_type state_ff;
   deq_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      cmd.exec  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            cmd.exec  = req_valid;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

// ===== sv/deq_dpath.sv =====
// ring storage, front index and count for the double-ended queue
module deq_dpath #(
   parameter int DEPTH = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  deq_pkg::deq_cmd_type cmd,
   input  logic [1:0]           req_type,
   input  deq_pkg::value_type   req_push_value,
   output deq_pkg::value_type   rsp_pop_value,
   output logic [1:0]           rsp_status,
   output logic                 rsp_now_empty
);
   import deq_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = IW + 1;

   value_type mem [DEPTH];

   logic [IW-1:0] front_ff;
   logic [IW-1:0] front_in;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;

   value_type     rd_data_ff;
   logic          pop_ok_ff;
   logic          pop_ok_in;
   logic [1:0]    status_ff;
   logic [1:0]    status_in;
   logic          empty_ff;

   logic [SW-1:0] tail_sum;
   logic [SW-1:0] last_sum;
   logic [IW-1:0] tail_pos;
   logic [IW-1:0] last_pos;
   logic [IW-1:0] front_dec;
   logic [IW-1:0] front_inc;
   logic          is_full;
   logic          is_empty;
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [IW-1:0] rd_addr;

   always_comb begin
      tail_sum = {1'b0, front_ff} + SW'(count_ff);
      last_sum = tail_sum - SW'(1);
      if (tail_sum >= SW'(DEPTH)) begin
         tail_pos = IW'(tail_sum - SW'(DEPTH));
      end else begin
         tail_pos = IW'(tail_sum);
      end
      if (last_sum >= SW'(DEPTH)) begin
         last_pos = IW'(last_sum - SW'(DEPTH));
      end else begin
         last_pos = IW'(last_sum);
      end
      if (front_ff == '0) begin
         front_dec = IW'(DEPTH - 1);
      end else begin
         front_dec = front_ff - IW'(1);
      end
      if (front_ff == IW'(DEPTH - 1)) begin
         front_inc = '0;
      end else begin
         front_inc = front_ff + IW'(1);
      end
      is_full  = (count_ff == CW'(DEPTH));
      is_empty = (count_ff == '0);
   end

   always_comb begin
      front_in  = front_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      wr_addr   = tail_pos;
      rd_addr   = front_ff;
      pop_ok_in = 1'b0;
      status_in = STAT_OK;
      case (req_type)
         REQ_PUSH_TAIL: begin
            if (is_full) begin
               status_in = STAT_FULL_ERROR;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         REQ_PUSH_HEAD: begin
            wr_addr = front_dec;
            if (is_full) begin
               status_in = STAT_FULL_ERROR;
            end else begin
               wr_en    = 1'b1;
               front_in = front_dec;
               count_in = count_ff + CW'(1);
            end
         end
         REQ_POP_TAIL: begin
            rd_addr = last_pos;
            if (is_empty) begin
               status_in = STAT_EMPTY_ERROR;
            end else begin
               pop_ok_in = 1'b1;
               count_in  = count_ff - CW'(1);
            end
         end
         REQ_POP_HEAD: begin
            if (is_empty) begin
               status_in = STAT_EMPTY_ERROR;
            end else begin
               pop_ok_in = 1'b1;
               front_in  = front_inc;
               count_in  = count_ff - CW'(1);
            end
         end
         default: begin
            status_in = STAT_OK;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         count_ff <= '0;
      end else if (cmd.exec) begin
         front_ff <= front_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (wr_en) begin
            mem[wr_addr] <= req_push_value;
         end
         rd_data_ff <= mem[rd_addr];
         pop_ok_ff  <= pop_ok_in;
         status_ff  <= status_in;
         empty_ff   <= (count_in == '0);
      end
   end

   assign rsp_pop_value = pop_ok_ff ? rd_data_ff : '0;
   assign rsp_status    = status_ff;
   assign rsp_now_empty = empty_ff;

endmodule

// ===== sv/double_ended_queue_top.sv =====
// top level of the bounded double-ended queue of 64-bit words
//
// request channel: req_valid, req_stall, req_type and req_push_value.
//    req_type selects push at back, push at front, pop from back or pop from front.
// response channel: rsp_valid, rsp_stall, rsp_pop_value, rsp_status, rsp_now_empty.
//    every request gives exactly one response word.
// a request is taken when the block is idle; its response is valid on the next
//    cycle.
// a new request is taken only after the previous response has left: the ring
//    storage is read through a registered port and the response register is
//    reused for each request.
// while rsp_stall is high the response word holds and req_stall stays high.
// a failed pop returns empty_error with zero data, a push onto a full queue
//    is dropped and returns full_error; neither changes the queue.
// reset empties the queue and sets the front index to zero; storage
//    contents are not cleared.
module double_ended_queue_top #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_type,
   input  deq_pkg::value_type req_push_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output deq_pkg::value_type rsp_pop_value,
   output logic [1:0]         rsp_status,
   output logic               rsp_now_empty
);
   import deq_pkg::*;

   deq_cmd_type cmd;

   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   deq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_type       (req_type),
      .req_push_value (req_push_value),
      .rsp_pop_value  (rsp_pop_value),
      .rsp_status     (rsp_status),
      .rsp_now_empty  (rsp_now_empty)
   );

endmodule

// ===== sv/deq_checker.sv =====
// port-level checks for the double-ended queue, bound to the top level
`include "double_ended_queue_top_defines.svh"

module deq_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input deq_pkg::value_type rsp_pop_value,
   input logic [1:0]         rsp_status,
   input logic               rsp_now_empty
);
   import deq_pkg::*;

   `DEQ_ASSERT_NEXT(a_accept_then_rsp, req_valid && !req_stall && !reset, rsp_valid)
   `DEQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall && !reset,
      rsp_valid && $stable(rsp_pop_value) && $stable(rsp_status) && $stable(rsp_now_empty))
   `DEQ_ASSERT_SAME(a_error_zero_data, rsp_valid && rsp_status != STAT_OK, rsp_pop_value == '0)
   `DEQ_ASSERT_SAME(a_error_empty_flag,
      rsp_valid && (rsp_status == STAT_EMPTY_ERROR || rsp_status == STAT_FULL_ERROR),
      rsp_now_empty == (rsp_status == STAT_EMPTY_ERROR))

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (.*);

// ===== sim/double_ended_queue_top_test.sv =====
// self-checking testbench for the double-ended queue: random bursts, stalls and a predictor
module double_ended_queue_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   import deq_pkg::*;

   localparam int RING_DEPTH  = 16;
   localparam int ITEM_TARGET = 550;
   localparam int IDLE_LIMIT  = 3000;

   typedef struct {
      logic [1:0] kind;
      value_type  value;
   } request_type;

   typedef struct {
      value_type  pop_value;
      logic [1:0] status;
      logic       now_empty;
   } answer_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_type = REQ_PUSH_TAIL;
   value_type  req_push_value = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   value_type  rsp_pop_value;
   logic [1:0] rsp_status;
   logic       rsp_now_empty;

   request_type pending_requests[$];
   answer_type  answers_due[$];
   int          errors = 0;

   // predicted queue contents
   value_type ring_mem [RING_DEPTH];
   logic [3:0] ring_front = '0;
   logic [4:0] ring_count = '0;

   double_ended_queue_top #(.DEPTH(RING_DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_push_value(req_push_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pop_value(rsp_pop_value),
      .rsp_status(rsp_status),
      .rsp_now_empty(rsp_now_empty)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic answer_type deque_apply(logic [1:0] kind, value_type value);
      answer_type ans;
      logic [3:0] slot;
      ans.pop_value = '0;
      ans.status = STAT_OK;
      case (kind)
         REQ_PUSH_TAIL, REQ_PUSH_HEAD: begin
            if (ring_count == RING_DEPTH) begin
               ans.status = STAT_FULL_ERROR;
            end else if (kind == REQ_PUSH_TAIL) begin
               slot = ring_front + ring_count[3:0];
               ring_mem[slot] = value;
               ring_count++;
            end else begin
               ring_front = ring_front - 4'd1;
               ring_mem[ring_front] = value;
               ring_count++;
            end
         end
         default: begin
            if (ring_count == 0) begin
               ans.status = STAT_EMPTY_ERROR;
            end else if (kind == REQ_POP_TAIL) begin
               slot = ring_front + ring_count[3:0] - 4'd1;
               ans.pop_value = ring_mem[slot];
               ring_count--;
            end else begin
               ans.pop_value = ring_mem[ring_front];
               ring_front = ring_front + 4'd1;
               ring_count--;
            end
         end
      endcase
      ans.now_empty = (ring_count == 0);
      return ans;
   endfunction

   function automatic value_type pick_value();
      case ($urandom_range(0, 7))
         0: return 64'h7FFF_FFFF_FFFF_FFFF;
         1: return 64'h8000_0000_0000_0000;
         2: return '1;
         3: return '0;
         4: return value_type'($urandom_range(0, 255));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic void add_request(logic [1:0] kind, value_type value);
      request_type r;
      r.kind = kind;
      r.value = value;
      pending_requests = {pending_requests, r};
   endfunction

   // driver: bursts of words with random gaps
   int burst_left = 1;
   int gap_left = 0;

   always @(posedge clock) begin
      request_type r;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left = 1;
         gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            answers_due = {answers_due, deque_apply(req_type, req_push_value)};
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
               r = pending_requests[0];
               pending_requests.delete(0);
               req_valid <= 1'b1;
               req_type <= r.kind;
               req_push_value <= r.value;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor and receiver stall pattern
   int answers_seen = 0;
   int hold_left = 0;
   int mode_left = 0;
   int stall_mode = 0;

   always @(posedge clock) begin
      answer_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (answers_due.size() == 0) begin
               $error("unexpected word: pop_value %h status %0d now_empty %0d",
                      rsp_pop_value, rsp_status, rsp_now_empty);
               errors++;
            end else begin
               want = answers_due[0];
               answers_due.delete(0);
               if (rsp_pop_value !== want.pop_value) begin
                  $error("pop_value expected %h actual %h", want.pop_value, rsp_pop_value);
                  errors++;
               end
               if (rsp_status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_status);
                  errors++;
               end
               if (rsp_now_empty !== want.now_empty) begin
                  $error("now_empty expected %0d actual %0d", want.now_empty, rsp_now_empty);
                  errors++;
               end
            end
            answers_seen++;
            // long hold-off so the request side backs up
            if (answers_seen == 150 || answers_seen == 400) hold_left = 80;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (mode_left <= 0) begin
               stall_mode = $urandom_range(0, 2);
               mode_left = $urandom_range(20, 60);
            end
            mode_left--;
            case (stall_mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               default: rsp_stall <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   // watchdog on cycles with no handshake
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles == IDLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      int phase;
      int phase_len;
      int push_pct;
      int total;

      // directed: empty pops, extremes, wrap of the front index
      add_request(REQ_POP_TAIL, 64'h1234_5678_9ABC_DEF0);
      add_request(REQ_POP_HEAD, '1);
      add_request(REQ_PUSH_HEAD, 64'h7FFF_FFFF_FFFF_FFFF);
      add_request(REQ_PUSH_TAIL, 64'h8000_0000_0000_0000);
      add_request(REQ_PUSH_HEAD, '0);
      add_request(REQ_PUSH_TAIL, 64'h5555_5555_5555_5555);
      add_request(REQ_PUSH_HEAD, 64'hAAAA_AAAA_AAAA_AAAA);
      add_request(REQ_POP_TAIL, '0);
      add_request(REQ_POP_HEAD, '0);
      add_request(REQ_POP_TAIL, '0);
      add_request(REQ_POP_HEAD, '0);
      add_request(REQ_POP_HEAD, '0);
      add_request(REQ_POP_TAIL, '0);
      add_request(REQ_PUSH_TAIL, '1);
      add_request(REQ_POP_HEAD, '0);
      add_request(REQ_PUSH_HEAD, 64'd1);
      add_request(REQ_POP_TAIL, '0);

      // random phases: filling, draining and mixed
      total = 0;
      while (total < ITEM_TARGET) begin
         phase = $urandom_range(0, 2);
         phase_len = $urandom_range(10, 40);
         push_pct = (phase == 0) ? 85 : (phase == 1) ? 15 : 50;
         repeat (phase_len) begin
            if ($urandom_range(0, 99) < push_pct)
               add_request($urandom_range(0, 1) ? REQ_PUSH_HEAD : REQ_PUSH_TAIL,
                           pick_value());
            else
               add_request($urandom_range(0, 1) ? REQ_POP_HEAD : REQ_POP_TAIL,
                           pick_value());
            total++;
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() > 0 || req_valid) @(posedge clock);
      while (answers_due.size() > 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (errors == 0 && answers_due.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== double_ended_queue_top.f =====
+incdir+sv
sv/deq_pkg.sv
sv/deq_ctrl.sv
sv/deq_dpath.sv
sv/double_ended_queue_top.sv
sv/deq_checker.sv
sim/double_ended_queue_top_test.sv
